// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// No dependencies; assertions are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, cond, expr)

`define ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

// ===== sv/thc_pkg.sv =====
// Package for the thermal cycle hysteresis controller: mode type, codes, widths.
// No dependencies.
`timescale 1ns / 1ps

package thc_pkg;

    localparam int TEMP_W    = 13;
    localparam int IN_TEMPS  = 4;
    localparam int THR_W     = 8;
    localparam int MS_W      = 32;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic signed [TEMP_W-1:0] SEED_MIN = 13'sd2400;
    localparam logic signed [TEMP_W-1:0] SEED_MAX = 13'sd0;

    typedef enum logic [1:0] {
        MODE_CAL   = 2'd0,
        MODE_OFF   = 2'd1,
        MODE_ON    = 2'd2,
        MODE_FAULT = 2'd3
    } t_mode;

    localparam logic [1:0] MOTOR_STOP = 2'd0;
    localparam logic [1:0] MOTOR_MIN  = 2'd1;
    localparam logic [1:0] MOTOR_MAX  = 2'd2;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_HOT  = 2'd1;
    localparam logic [1:0] FAULT_COLD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OVER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDER    = 3'd4;

endpackage

// ===== sv/thermal_cycle_hysteresis_controller_unit.sv =====
// Thermal cycle hysteresis controller: input register, one-pass update, result register.
// Depends on thc_pkg and assert_macros.svh.
//
//   channel   handshake              payload
//   input     i_valid / o_ready      i_op, i_temp_0..3, i_now_ms
//   result    o_valid / i_ready      o_run_mode, o_motor_level, o_fan_on,
//                                    o_fault_code, o_cycle_count
//   config    i_cfg_wr_en            i_cfg_idx, i_cfg_data
//
// One word per cycle sustained while results are taken; a word passes the input register, then the result register.
// The mode/fan/motor/fault/cycle registers double as the result register.
// Reset is synchronous: control and state clear, config registers load defaults.
// A held result holds the input register; o_ready is high while it is empty or while its word moves on.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module thermal_cycle_hysteresis_controller_unit
    import thc_pkg::*;
#(
    parameter int SENSORS = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DAT_W-1:0]     i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_op,
    input  logic signed [TEMP_W-1:0] i_temp_0,
    input  logic signed [TEMP_W-1:0] i_temp_1,
    input  logic signed [TEMP_W-1:0] i_temp_2,
    input  logic signed [TEMP_W-1:0] i_temp_3,
    input  logic [MS_W-1:0]          i_now_ms,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_run_mode,
    output logic [1:0]               o_motor_level,
    output logic                     o_fan_on,
    output logic [1:0]               o_fault_code,
    output logic [CNT_W-1:0]         o_cycle_count
);

    localparam int SUM_W = TEMP_W + $clog2(SENSORS) + 1;
    localparam logic [SUM_W-1:0] AVG_SCALE = SUM_W'(16 * SENSORS);

    logic [THR_W-1:0]         r_low_thr;
    logic [THR_W-1:0]         r_high_thr;
    logic [MS_W-1:0]          r_cal_ms;
    logic signed [TEMP_W-1:0] r_over_lim;
    logic signed [TEMP_W-1:0] r_under_lim;

    logic                     r_in_valid;
    logic                     r_op;
    logic signed [TEMP_W-1:0] r_temp [IN_TEMPS];
    logic [MS_W-1:0]          r_now_ms;

    logic                     r_out_valid;
    t_mode                    r_mode;
    logic                     r_cool_dir;
    logic [1:0]               r_motor;
    logic [1:0]               r_fault;
    logic [CNT_W-1:0]         r_cycle;
    logic                     r_fan;

    t_mode                    n_mode;
    logic                     n_cool_dir;
    logic [1:0]               n_motor;
    logic [1:0]               n_fault;
    logic [CNT_W-1:0]         n_cycle;
    logic                     n_fan;

    logic                     w_advance;
    logic signed [TEMP_W-1:0] w_smp [SENSORS];
    logic signed [TEMP_W-1:0] w_min;
    logic signed [TEMP_W-1:0] w_max;
    logic signed [SUM_W-1:0]  w_sum;
    logic [SUM_W-1:0]         w_hi_lim;
    logic [SUM_W-1:0]         w_lo_lim;
    logic                     w_hot;
    logic                     w_cold;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr   <= THR_W'(30);
            r_high_thr  <= THR_W'(60);
            r_cal_ms    <= MS_W'(60000);
            r_over_lim  <= TEMP_W'(1600);
            r_under_lim <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_LOW_THR:  r_low_thr   <= i_cfg_data[THR_W-1:0];
                CFG_HIGH_THR: r_high_thr  <= i_cfg_data[THR_W-1:0];
                CFG_CAL_MS:   r_cal_ms    <= i_cfg_data[MS_W-1:0];
                CFG_OVER:     r_over_lim  <= i_cfg_data[TEMP_W-1:0];
                CFG_UNDER:    r_under_lim <= i_cfg_data[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op      <= i_op;
            r_temp[0] <= i_temp_0;
            r_temp[1] <= i_temp_1;
            r_temp[2] <= i_temp_2;
            r_temp[3] <= i_temp_3;
            r_now_ms  <= i_now_ms;
        end
    end

    // samples beyond the four inputs read as zero
    for (genvar g = 0; g < SENSORS; g++) begin : g_smp
        if (g < IN_TEMPS) begin : g_in
            assign w_smp[g] = r_temp[g];
        end else begin : g_zero
            assign w_smp[g] = '0;
        end
    end

    always_comb begin
        w_min = SEED_MIN;
        w_max = SEED_MAX;
        w_sum = '0;
        for (int i = 0; i < SENSORS; i++) begin
            w_sum = w_sum + SUM_W'(w_smp[i]);
            if (w_smp[i] < w_min) begin
                w_min = w_smp[i];
            end
            if (w_smp[i] > w_max) begin
                w_max = w_smp[i];
            end
        end
    end

    assign w_hi_lim = SUM_W'(r_high_thr) * AVG_SCALE;
    assign w_lo_lim = SUM_W'(r_low_thr) * AVG_SCALE;
    assign w_hot    = w_max >= r_over_lim;
    assign w_cold   = w_min <= r_under_lim;

    always_comb begin
        n_mode     = r_mode;
        n_cool_dir = r_cool_dir;
        n_motor    = r_motor;
        n_fault    = r_fault;
        n_cycle    = r_cycle;
        n_fan      = r_fan;
        if (r_op) begin
            n_mode  = MODE_FAULT;
            n_fan   = 1'b1;
            n_motor = MOTOR_MIN;
        end else if (r_mode == MODE_FAULT) begin
            n_motor = MOTOR_STOP;
        end else begin
            unique case (r_mode)
                MODE_CAL: begin
                    n_motor = MOTOR_MIN;
                    if (r_now_ms < r_cal_ms) begin
                        n_fan = 1'b1;
                    end else begin
                        n_mode = MODE_ON;
                        n_fan  = 1'b0;
                    end
                end
                MODE_OFF: begin
                    n_fan   = 1'b1;
                    n_motor = MOTOR_MIN;
                end
                default: begin
                    n_fan   = 1'b0;
                    n_motor = MOTOR_MAX;
                end
            endcase
            if (w_hot || w_cold) begin
                n_fault = w_hot ? FAULT_HOT : FAULT_COLD;
                n_mode  = MODE_FAULT;
                n_fan   = 1'b0;
                n_motor = MOTOR_STOP;
            end else if (!r_cool_dir) begin
                if (w_sum > $signed(w_hi_lim)) begin
                    n_cool_dir = 1'b1;
                    n_mode     = MODE_OFF;
                end
            end else if (w_sum < $signed(w_lo_lim)) begin
                n_cool_dir = 1'b0;
                n_cycle    = r_cycle + CNT_W'(1);
                n_mode     = MODE_ON;
                n_motor    = MOTOR_MAX;
            end
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_mode      <= MODE_CAL;
            r_cool_dir  <= 1'b0;
            r_motor     <= MOTOR_STOP;
            r_fault     <= FAULT_NONE;
            r_cycle     <= '0;
            r_fan       <= 1'b0;
        end else begin
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_cool_dir  <= n_cool_dir;
                r_motor     <= n_motor;
                r_fault     <= n_fault;
                r_cycle     <= n_cycle;
                r_fan       <= n_fan;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_run_mode    = r_mode;
    assign o_motor_level = r_motor;
    assign o_fan_on      = r_fan;
    assign o_fault_code  = r_fault;
    assign o_cycle_count = r_cycle;

    `ASSERT_IMPLY(a_fault_in_mode, i_clk, i_rst_n, r_fault != FAULT_NONE, r_mode == MODE_FAULT)
    `ASSERT_NEXT(a_fault_sticks, i_clk, i_rst_n, r_mode == MODE_FAULT, r_mode == MODE_FAULT)
    `ASSERT_NEXT(a_cycle_hold, i_clk, i_rst_n, !w_advance, $stable(r_cycle))
    `ASSERT_NEXT(a_held_result, i_clk, i_rst_n, r_out_valid && !i_ready, r_out_valid && $stable(r_mode))

endmodule

// ===== test/tb_thermal_cycle_hysteresis_controller_unit.sv =====
// Testbench for thermal_cycle_hysteresis_controller_unit: directed and random update words
// checked against an in-bench model of the mode machine, hysteresis and fault latch.
// Depends on thc_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb_thermal_cycle_hysteresis_controller_unit;
    import thc_pkg::*;

    localparam int   SENSOR_COUNT  = 4;
    localparam int   CYCLE_LIMIT   = 200000;
    localparam int   SETTLE_CYCLES = 6;
    localparam int   RANDOM_PHASES = 8;
    localparam int   PHASE_WORDS   = 90;
    localparam logic OP_UPDATE     = 1'b0;
    localparam logic OP_LOCK_OFF   = 1'b1;

    typedef logic signed [TEMP_W-1:0] t_temp;

    typedef struct packed {
        t_mode            mode;
        logic [1:0]       motor;
        logic             fan;
        logic [1:0]       fault;
        logic [CNT_W-1:0] cycles;
    } t_status;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_op;
    t_temp                i_temp_0;
    t_temp                i_temp_1;
    t_temp                i_temp_2;
    t_temp                i_temp_3;
    logic [MS_W-1:0]      i_now_ms;
    logic                 o_valid;
    logic                 i_ready;
    logic [1:0]           o_run_mode;
    logic [1:0]           o_motor_level;
    logic                 o_fan_on;
    logic [1:0]           o_fault_code;
    logic [CNT_W-1:0]     o_cycle_count;

    // controller model state and register copies
    t_mode            st_mode;
    logic             st_falling;
    logic [1:0]       st_motor;
    logic             st_fan;
    logic [1:0]       st_fault;
    logic [CNT_W-1:0] st_cycles;
    logic [THR_W-1:0] cfg_low;
    logic [THR_W-1:0] cfg_high;
    logic [MS_W-1:0]  cfg_cal_ms;
    t_temp            cfg_over;
    t_temp            cfg_under;

    t_status expected_status_q[$];

    bit src_idle;
    bit sink_idle;
    int sink_hold;
    int sink_gap;
    int clk_cycles;
    int fail_count;
    int words_sent;
    int results_checked;

    thermal_cycle_hysteresis_controller_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_temp_0      (i_temp_0),
        .i_temp_1      (i_temp_1),
        .i_temp_2      (i_temp_2),
        .i_temp_3      (i_temp_3),
        .i_now_ms      (i_now_ms),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_run_mode    (o_run_mode),
        .o_motor_level (o_motor_level),
        .o_fan_on      (o_fan_on),
        .o_fault_code  (o_fault_code),
        .o_cycle_count (o_cycle_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        clk_cycles++;
        if (clk_cycles > CYCLE_LIMIT) begin
            $display("thermal_cycle_hysteresis_controller_unit verification failed");
            $finish;
        end
    end

    function automatic t_status controller_step(input logic op, input t_temp t0, t1, t2, t3,
                                                input logic [MS_W-1:0] now_ms);
        int      smp [SENSOR_COUNT];
        int      lo;
        int      hi;
        int      total;
        t_status res;
        smp[0] = t0;
        smp[1] = t1;
        smp[2] = t2;
        smp[3] = t3;
        if (op == OP_LOCK_OFF) begin
            st_mode  = MODE_FAULT;
            st_fan   = 1'b1;
            st_motor = MOTOR_MIN;
        end else if (st_mode == MODE_FAULT) begin
            st_motor = MOTOR_STOP;
        end else begin
            case (st_mode)
                MODE_CAL: begin
                    if (now_ms < cfg_cal_ms) begin
                        st_fan = 1'b1;
                    end else begin
                        st_mode = MODE_ON;
                        st_fan  = 1'b0;
                    end
                    st_motor = MOTOR_MIN;
                end
                MODE_OFF: begin
                    st_fan   = 1'b1;
                    st_motor = MOTOR_MIN;
                end
                default: begin
                    st_fan   = 1'b0;
                    st_motor = MOTOR_MAX;
                end
            endcase
            lo    = SEED_MIN;
            hi    = SEED_MAX;
            total = 0;
            foreach (smp[i]) begin
                total += smp[i];
                if (smp[i] < lo) lo = smp[i];
                if (smp[i] > hi) hi = smp[i];
            end
            if (hi >= cfg_over || lo <= cfg_under) begin
                st_fault = (hi >= cfg_over) ? FAULT_HOT : FAULT_COLD;
                st_mode  = MODE_FAULT;
                st_fan   = 1'b0;
                st_motor = MOTOR_STOP;
            end else if (!st_falling) begin
                if (total > int'(cfg_high) * 16 * SENSOR_COUNT) begin
                    st_falling = 1'b1;
                    st_mode    = MODE_OFF;
                end
            end else if (total < int'(cfg_low) * 16 * SENSOR_COUNT) begin
                st_falling = 1'b0;
                st_cycles  = st_cycles + 1'b1;
                st_mode    = MODE_ON;
                st_motor   = MOTOR_MAX;
            end
        end
        res.mode   = st_mode;
        res.motor  = st_motor;
        res.fan    = st_fan;
        res.fault  = st_fault;
        res.cycles = st_cycles;
        return res;
    endfunction

    // spread around a center, kept strictly inside the fault limits
    function automatic t_temp sample_near(input int center);
        int v;
        v = center + int'($urandom_range(0, 400)) - 200;
        if (v <= cfg_under) v = int'(cfg_under) + 1;
        if (v >= cfg_over) v = int'(cfg_over) - 1;
        return t_temp'(v);
    endfunction

    function automatic t_temp sample_between();
        int span;
        span = int'(cfg_over) - int'(cfg_under) - 2;
        return t_temp'(int'($urandom_range(0, span)) + int'(cfg_under) + 1);
    endfunction

    function automatic t_temp sample_full();
        return t_temp'(int'($urandom_range(0, 3040)) - 640);
    endfunction

    task automatic send_word(input logic op, input t_temp t0, t1, t2, t3,
                             input logic [MS_W-1:0] now_ms);
        int gap;
        gap = src_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op     <= op;
        i_temp_0 <= t0;
        i_temp_1 <= t1;
        i_temp_2 <= t2;
        i_temp_3 <= t3;
        i_now_ms <= now_ms;
        i_valid  <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_status_q.push_back(controller_step(op, t0, t1, t2, t3, now_ms));
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        i_cfg_wr_en <= 1'b1;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        case (idx)
            CFG_LOW_THR:  cfg_low    = data[THR_W-1:0];
            CFG_HIGH_THR: cfg_high   = data[THR_W-1:0];
            CFG_CAL_MS:   cfg_cal_ms = data[MS_W-1:0];
            CFG_OVER:     cfg_over   = data[TEMP_W-1:0];
            CFG_UNDER:    cfg_under  = data[TEMP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int low, input int high, input int over, input int under);
        write_reg(CFG_LOW_THR, low);
        write_reg(CFG_HIGH_THR, high);
        write_reg(CFG_OVER, over);
        write_reg(CFG_UNDER, under);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_status_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_calibration();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        write_reg(CFG_CAL_MS, 32'hFFFF_FFFF);
        send_word(OP_UPDATE, 720, 720, 720, 720, 32'd0);
        send_word(OP_UPDATE, 700, 640, 800, 760, 32'd1);
        send_word(OP_UPDATE, 720, 720, 720, 720, $urandom());
        send_word(OP_UPDATE, 680, 700, 720, 740, 32'hFFFF_FFFE);
        // leave calibration either on time or through the high threshold
        if ($urandom_range(0, 1) == 0) begin
            send_word(OP_UPDATE, 720, 720, 720, 720, 32'hFFFF_FFFF);
        end else begin
            send_word(OP_UPDATE, 1200, 1200, 1200, 1200, 32'd5);
        end
        send_word(OP_UPDATE, 720, 720, 720, 720, $urandom());
        wait_idle();
    endtask

    task automatic test_hysteresis_edges();
        configure(40, 50, 1600, 0);
        send_word(OP_UPDATE, 800, 800, 800, 800, $urandom());
        send_word(OP_UPDATE, 800, 800, 800, 801, $urandom());
        send_word(OP_UPDATE, 640, 640, 640, 640, $urandom());
        send_word(OP_UPDATE, 640, 640, 640, 639, $urandom());
        wait_idle();
        configure(0, 0, 2400, -640);
        send_word(OP_UPDATE, 2399, -639, -639, -639, $urandom());
        send_word(OP_UPDATE, 0, 0, 0, 0, $urandom());
        send_word(OP_UPDATE, -1, 0, 0, 0, $urandom());
        send_word(OP_UPDATE, -639, -639, -639, -639, $urandom());
        wait_idle();
        configure(150, 150, 2400, -640);
        send_word(OP_UPDATE, 2399, 2399, 2399, 2399, $urandom());
        send_word(OP_UPDATE, 2399, 2399, 2399, 2398, $urandom());
        wait_idle();
    endtask

    task automatic test_random_cycles();
        int phase;
        int n;
        int k;
        int run_len;
        int center;
        int lo_thr;
        int hi_thr;
        bit above;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            src_idle  = $urandom_range(0, 3) != 0;
            sink_idle = $urandom_range(0, 3) != 0;
            lo_thr    = $urandom_range(0, 150);
            hi_thr    = (phase % 4 == 3) ? $urandom_range(0, lo_thr) : $urandom_range(lo_thr, 150);
            configure(lo_thr, hi_thr, $urandom_range(2048, 2400), -int'($urandom_range(0, 640)));
            write_reg(CFG_CAL_MS, $urandom());
            above = 1'b1;
            n     = 0;
            while (n < PHASE_WORDS) begin
                run_len = $urandom_range(2, 8);
                if (above) center = (int'(cfg_high) + int'($urandom_range(1, 10))) * 16;
                else center = (int'(cfg_low) - int'($urandom_range(1, 10))) * 16;
                for (k = 0; k < run_len && n < PHASE_WORDS; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_word(OP_UPDATE, sample_between(), sample_between(),
                                  sample_between(), sample_between(), $urandom());
                    end else begin
                        send_word(OP_UPDATE, sample_near(center), sample_near(center),
                                  sample_near(center), sample_near(center), $urandom());
                    end
                    n++;
                end
                above = !above;
            end
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        sink_hold = 48;
        repeat (24) begin
            send_word(OP_UPDATE, sample_between(), sample_between(),
                      sample_between(), sample_between(), $urandom());
        end
        wait_idle();
    endtask

    task automatic test_faults();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        case ($urandom_range(0, 2))
            0: begin
                configure(cfg_low, cfg_high, 2400, 0);
                send_word(OP_UPDATE, 2400, 100, 100, 100, $urandom());
            end
            1: begin
                configure(cfg_low, cfg_high, 2400, -640);
                send_word(OP_UPDATE, -640, 100, 100, 100, $urandom());
            end
            default: begin
                // both limits fire; too hot wins
                configure(cfg_low, cfg_high, -640, 2400);
                send_word(OP_UPDATE, 100, 200, 300, 400, $urandom());
            end
        endcase
        send_word(OP_UPDATE, 720, 720, 720, 720, $urandom());
        send_word(OP_LOCK_OFF, 720, 720, 720, 720, $urandom());
        send_word(OP_UPDATE, 720, 720, 720, 720, $urandom());
        send_word(OP_LOCK_OFF, -640, 2400, -640, 2400, 32'hFFFF_FFFF);
        wait_idle();
        configure(150, 0, 2400, -640);
        configure(0, 150, -640, 2400);
        write_reg(CFG_CAL_MS, 32'd0);
        src_idle  = $urandom_range(0, 1);
        sink_idle = $urandom_range(0, 1);
        repeat (60) begin
            send_word(($urandom_range(0, 2) == 0) ? OP_LOCK_OFF : OP_UPDATE, sample_full(),
                      sample_full(), sample_full(), sample_full(), $urandom());
        end
        wait_idle();
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            i_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_status
        t_status want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_status_q.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                want = expected_status_q.pop_front();
                if (o_run_mode !== want.mode) begin
                    $error("run_mode: expected %0d, got %0d", want.mode, o_run_mode);
                    fail_count++;
                end
                if (o_motor_level !== want.motor) begin
                    $error("motor_level: expected %0d, got %0d", want.motor, o_motor_level);
                    fail_count++;
                end
                if (o_fan_on !== want.fan) begin
                    $error("fan_on: expected %0d, got %0d", want.fan, o_fan_on);
                    fail_count++;
                end
                if (o_fault_code !== want.fault) begin
                    $error("fault_code: expected %0d, got %0d", want.fault, o_fault_code);
                    fail_count++;
                end
                if (o_cycle_count !== want.cycles) begin
                    $error("cycle_count: expected %0d, got %0d", want.cycles, o_cycle_count);
                    fail_count++;
                end
            end
            results_checked++;
            sink_gap = sink_idle ? $urandom_range(0, 4) : 0;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_op        = OP_UPDATE;
        i_temp_0    = '0;
        i_temp_1    = '0;
        i_temp_2    = '0;
        i_temp_3    = '0;
        i_now_ms    = '0;
        i_ready     = 1'b0;
        st_mode     = MODE_CAL;
        st_falling  = 1'b0;
        st_motor    = MOTOR_STOP;
        st_fan      = 1'b0;
        st_fault    = FAULT_NONE;
        st_cycles   = '0;
        cfg_low     = 8'd30;
        cfg_high    = 8'd60;
        cfg_cal_ms  = 32'd60000;
        cfg_over    = 13'sd1600;
        cfg_under   = 13'sd0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_calibration();
        test_hysteresis_edges();
        test_random_cycles();
        test_backpressure();
        test_faults();
        $display("summary: %0d words, %0d results checked, %0d heat-cool cycles, fault %0d",
                 words_sent, results_checked, st_cycles, st_fault);
        $display("summary: calibration exit, threshold edges, random sweeps, long stall, fault latch");
        if (fail_count == 0) begin
            $display("thermal_cycle_hysteresis_controller_unit verification clean");
        end else begin
            $display("thermal_cycle_hysteresis_controller_unit verification failed");
        end
        $finish;
    end

endmodule
